/* design/htbf_pkg.sv */
// Shared types, codes and constants of the HDLC transmit bit framer.
// Used by every module of the framer; depends on nothing else.
package htbf_pkg;

    // Stream payload widths, zero-filled to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // APB port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_FRAME_BIT_LIMIT    = 2'd0;
    localparam logic [1:0] REG_SCRAMBLE_ENABLE    = 2'd1;
    localparam logic [1:0] REG_SCRAMBLE_START_BIT = 2'd2;
    localparam logic [1:0] REG_NRZI_ENABLE        = 2'd3;

    localparam logic [15:0] LIMIT_RESET     = 16'd4096;
    localparam logic [15:0] SCR_START_RESET = 16'd32;

    // Command codes on the input stream.
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_SYNC  = 3'd1;
    localparam logic [2:0] CMD_FLAG  = 3'd2;
    localparam logic [2:0] CMD_DATA  = 3'd3;
    localparam logic [2:0] CMD_CRC   = 3'd4;

    localparam logic [7:0]  SYNC_BYTE = 8'h00;
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN = 3'd5;
    localparam int          SCR_TAP_HI = 16;
    localparam int          SCR_TAP_LO = 11;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_RAW,
        KIND_DATA,
        KIND_CRC
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_val;
    } q_entry_t;

    typedef struct packed {
        logic [15:0] frame_bit_limit;
        logic        scramble_enable;
        logic [15:0] scramble_start_bit;
        logic        nrzi_enable;
    } cfg_t;

    // One step of the reflected CRC-16.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
        logic [15:0] c;
        c = crc ^ {15'd0, b};
        if (c[0]) begin
            crc_step = (c >> 1) ^ CRC_POLY;
        end else begin
            crc_step = c >> 1;
        end
    endfunction

endpackage

/* design/htbf_regs.sv */
// APB register file of the HDLC transmit bit framer.
// Depends on htbf_pkg for register indexes, reset values and the cfg_t struct.
module htbf_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htbf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [htbf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [htbf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output htbf_pkg::cfg_t                    cfg
);
    import htbf_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_bit_limit    <= LIMIT_RESET;
            cfg_reg.scramble_enable    <= 1'b0;
            cfg_reg.scramble_start_bit <= SCR_START_RESET;
            cfg_reg.nrzi_enable        <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_BIT_LIMIT:    cfg_reg.frame_bit_limit    <= pwdata[15:0];
                REG_SCRAMBLE_ENABLE:    cfg_reg.scramble_enable    <= pwdata[0];
                REG_SCRAMBLE_START_BIT: cfg_reg.scramble_start_bit <= pwdata[15:0];
                REG_NRZI_ENABLE:        cfg_reg.nrzi_enable        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_BIT_LIMIT:    prdata = {16'd0, cfg_reg.frame_bit_limit};
            REG_SCRAMBLE_ENABLE:    prdata = {31'd0, cfg_reg.scramble_enable};
            REG_SCRAMBLE_START_BIT: prdata = {16'd0, cfg_reg.scramble_start_bit};
            REG_NRZI_ENABLE:        prdata = {31'd0, cfg_reg.nrzi_enable};
            default:                prdata = '0;
        endcase
    end

endmodule

/* design/htbf_front.sv */
// Front end of the framer: takes command requests, decodes them into work kinds
// and queues them for the bit engine. Depends on htbf_pkg.
module htbf_front #(
    parameter int QUEUE_DEPTH = htbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] cmd, [10:3] data_byte, rest zero
    input  logic [htbf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             q_valid,
    output htbf_pkg::q_entry_t               q_entry,
    input  logic                             q_pop
);
    import htbf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [2:0] cmd;
    logic [7:0] data_byte;
    q_entry_t   dec_entry;
    logic       dec_known;
    logic       push;

    assign cmd       = s_tdata[2:0];
    assign data_byte = s_tdata[10:3];

    // Unknown codes are accepted and dropped here; they never reach the engine.
    always_comb begin
        dec_known          = 1'b1;
        dec_entry.kind     = KIND_START;
        dec_entry.byte_val = data_byte;
        case (cmd)
            CMD_START: dec_entry.kind = KIND_START;
            CMD_SYNC: begin
                dec_entry.kind     = KIND_RAW;
                dec_entry.byte_val = SYNC_BYTE;
            end
            CMD_FLAG: begin
                dec_entry.kind     = KIND_RAW;
                dec_entry.byte_val = FLAG_BYTE;
            end
            CMD_DATA: dec_entry.kind = KIND_DATA;
            CMD_CRC:  dec_entry.kind = KIND_CRC;
            default:  dec_known = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid & s_tready & dec_known;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec_entry;
        end
    end

endmodule

/* design/htbf_back.sv */
// Bit engine of the framer: runs queued commands one line bit per cycle while the output is not stalled, through
// CRC, zero stuffing, scrambler and NRZI into an output register. Depends on htbf_pkg.
module htbf_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  htbf_pkg::cfg_t                   cfg,
    input  logic                             q_valid,
    input  htbf_pkg::q_entry_t               q_entry,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] line_bit, rest zero
    output logic [htbf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    // [0] frame_full
    output logic [htbf_pkg::M_TUSER_W-1:0]   m_tuser
);
    import htbf_pkg::*;

    // Command in progress.
    logic        busy_reg, busy_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] sh_reg, sh_next;
    logic [3:0]  idx_reg, idx_next;
    logic        stuff_reg, stuff_next;

    // Frame state.
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  ones_reg, ones_next;
    logic [15:0] count_reg, count_next;
    logic [16:0] scr_reg, scr_next;
    logic        tone_reg, tone_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic out_line_reg, out_line_next;
    logic out_last_reg, out_last_next;
    logic out_full_reg, out_full_next;

    logic       advance;
    logic       bit_val;
    logic       stuffed;
    logic       is_data;
    logic [3:0] last_idx;
    logic       can_send;
    logic       hit_limit;
    logic [2:0] ones_inc;
    logic       need_stuff;
    logic       more;
    logic       scr_on;
    logic       scr_out;
    logic       v1;
    logic       tone_new;
    logic       line;
    logic       done;

    always_comb begin
        busy_next      = busy_reg;
        kind_next      = kind_reg;
        sh_next        = sh_reg;
        idx_next       = idx_reg;
        stuff_next     = stuff_reg;
        crc_next       = crc_reg;
        ones_next      = ones_reg;
        count_next     = count_reg;
        scr_next       = scr_reg;
        tone_next      = tone_reg;
        out_valid_next = out_valid_reg;
        out_line_next  = out_line_reg;
        out_last_next  = out_last_reg;
        out_full_next  = out_full_reg;
        q_pop          = 1'b0;
        done           = 1'b0;

        advance    = !out_valid_reg || m_tready;
        bit_val    = stuff_reg ? 1'b0 : sh_reg[0];
        stuffed    = (kind_reg == KIND_DATA) || (kind_reg == KIND_CRC);
        is_data    = stuffed && !stuff_reg;
        last_idx   = (kind_reg == KIND_CRC) ? 4'd15 : 4'd7;
        can_send   = count_reg < cfg.frame_bit_limit;
        // The bit after this one would fall past the limit.
        hit_limit  = ({1'b0, count_reg} + 17'd1) >= {1'b0, cfg.frame_bit_limit};
        // The run count saturates, since any run of five or more forces a stuffed zero.
        ones_inc   = (ones_reg == 3'd7) ? ones_reg : ones_reg + 3'd1;
        need_stuff = is_data && bit_val && (ones_inc >= STUFF_RUN);
        more       = need_stuff || (idx_reg != last_idx);
        scr_on     = cfg.scramble_enable && (count_reg >= cfg.scramble_start_bit);
        scr_out    = bit_val ^ scr_reg[SCR_TAP_HI] ^ scr_reg[SCR_TAP_LO];
        v1         = scr_on ? scr_out : bit_val;
        tone_new   = v1 ? tone_reg : ~tone_reg;
        line       = cfg.nrzi_enable ? tone_new : v1;

        if (advance) begin
            out_valid_next = 1'b0;
            if (busy_reg) begin
                // A data bit enters the CRC even when the limit drops it.
                if (is_data) begin
                    crc_next = crc_step(crc_reg, bit_val);
                end
                if (can_send) begin
                    count_next = count_reg + 16'd1;
                    if (scr_on) begin
                        scr_next = {scr_reg[15:0], scr_out};
                    end
                    if (cfg.nrzi_enable) begin
                        tone_next = tone_new;
                    end
                    if (!stuffed) begin
                        if (!bit_val) begin
                            ones_next = '0;
                        end
                    end else if (is_data && bit_val) begin
                        ones_next = ones_inc;
                    end else begin
                        ones_next = '0;
                    end
                    out_valid_next = 1'b1;
                    out_line_next  = line;
                    out_last_next  = !more || hit_limit;
                    out_full_next  = more && hit_limit;
                    done           = !more;
                    if (more) begin
                        if (need_stuff) begin
                            stuff_next = 1'b1;
                        end else begin
                            stuff_next = 1'b0;
                            idx_next   = idx_reg + 4'd1;
                            sh_next    = sh_reg >> 1;
                        end
                    end
                end else begin
                    done = 1'b1;
                end
            end

            if (!busy_reg || done) begin
                busy_next = 1'b0;
                if (q_valid) begin
                    q_pop      = 1'b1;
                    kind_next  = q_entry.kind;
                    idx_next   = '0;
                    stuff_next = 1'b0;
                    case (q_entry.kind)
                        KIND_START: begin
                            count_next = '0;
                            ones_next  = '0;
                            tone_next  = 1'b0;
                            scr_next   = '0;
                            crc_next   = CRC_INIT;
                        end
                        KIND_RAW, KIND_DATA: begin
                            busy_next = 1'b1;
                            sh_next   = {8'd0, q_entry.byte_val};
                        end
                        KIND_CRC: begin
                            busy_next = 1'b1;
                            sh_next   = ~crc_next;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            stuff_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
            ones_reg      <= '0;
            count_reg     <= '0;
            scr_reg       <= '0;
            tone_reg      <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            stuff_reg     <= stuff_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            ones_reg      <= ones_next;
            count_reg     <= count_next;
            scr_reg       <= scr_next;
            tone_reg      <= tone_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        sh_reg       <= sh_next;
        idx_reg      <= idx_next;
        out_line_reg <= out_line_next;
        out_last_reg <= out_last_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_line_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = M_TUSER_W'(out_full_reg);

endmodule

/* design/hdlc_tx_bit_framer_core.sv */
// Top level of the HDLC transmit bit framer: register file, command front end
// and bit engine. Depends on htbf_pkg, htbf_regs, htbf_front and htbf_back.
//
// The framer turns command requests (start frame, sync, flag, data byte,
// send CRC) into a stream of line bits, one result per bit, with tlast on the
// final bit of each command and tuser[0] set when the frame bit limit cut that
// command short. The bit engine produces one line bit per clock while the
// output is not stalled; a sync or flag gives 8 line bits, a data byte 8 to 10
// and a CRC 16 to 20 depending on the zeros stuffed; a start frame makes no
// result. When the limit drops a bit, the engine abandons the rest of that
// command. Requests queue ahead of the engine (QUEUE_DEPTH entries), so
// the next command is taken while the current one is still being sent and the
// engine moves straight from the last bit of one command to the first of the
// next. Unknown command codes are accepted and discarded. Registers are only
// to be written while no command is pending or in progress.
module hdlc_tx_bit_framer_core #(
    parameter int QUEUE_DEPTH = htbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] cmd, [10:3] data_byte, rest zero
    input  logic [htbf_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] line_bit, rest zero
    output logic [htbf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // [0] frame_full
    output logic [htbf_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htbf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [htbf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [htbf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import htbf_pkg::*;

    cfg_t     cfg;
    logic     q_valid;
    q_entry_t q_entry;
    logic     q_pop;

    htbf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    htbf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    htbf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for the HDLC transmit bit framer: a directed table, then random frames and noise
// under several flow-control patterns, each line bit checked against typed table bits or a local bit-level model.
// Depends on htbf_pkg and hdlc_tx_bit_framer_core.
module tb;
    import htbf_pkg::*;

    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         PHASE_ITEMS  = 45;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  cmd;
        logic [1:0]  reg_idx;
        logic [15:0] val;
        logic        typed;
        logic [4:0]  nbits;
        logic [19:0] bits;
        logic        full;
    } dir_row_t;

    typedef struct packed {
        logic line_bit;
        logic last_bit;
        logic frame_full;
    } line_res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Typed expectation that travels with the request currently offered.
    logic        row_typed = 1'b0;
    logic [4:0]  row_n = '0;
    logic [19:0] row_bits = '0;
    logic        row_full = 1'b0;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_left = 0;
    int err_cnt = 0;
    int items_sent = 0;

    // Local copy of the framer state and its registers.
    cfg_t        cfg_now = '{LIMIT_RESET, 1'b0, SCR_START_RESET, 1'b0};
    logic [15:0] crc_acc = CRC_INIT;
    logic [7:0]  ones_cnt = '0;
    logic [15:0] bit_idx = '0;
    logic [16:0] scr_shift = '0;
    logic        tone = 1'b0;

    line_res_t cmd_bits[$];
    line_res_t line_bits_due[$];

    dir_row_t dir_rows [0:31] = '{
        '{ROW_CMD, CMD_START,  2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_SYNC,   2'd0, 16'h0000, 1'b1, 5'd8, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_FLAG,   2'd0, 16'h0000, 1'b1, 5'd8, 20'h0007E, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h0000, 1'b1, 5'd8, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h00FF, 1'b1, 5'd9, 20'h001DF, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h00FF, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_CRC,    2'd0, 16'h0000, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_BAD_LO, 2'd0, 16'h00FF, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_BAD_HI, 2'd0, 16'h00FF, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h0080, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CFG, CMD_START,  REG_FRAME_BIT_LIMIT, 16'd0, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CMD, CMD_START,  2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_FLAG,   2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h00FF, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CFG, CMD_START,  REG_FRAME_BIT_LIMIT, 16'd3, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CMD, CMD_START,  2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_SYNC,   2'd0, 16'h0000, 1'b1, 5'd3, 20'h00000, 1'b1},
        '{ROW_CMD, CMD_SYNC,   2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CFG, CMD_START,  REG_FRAME_BIT_LIMIT, 16'hFFFF, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CFG, CMD_START,  REG_SCRAMBLE_ENABLE, 16'd1, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CFG, CMD_START,  REG_SCRAMBLE_START_BIT, 16'd0, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CFG, CMD_START,  REG_NRZI_ENABLE, 16'd1, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CMD, CMD_START,  2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_SYNC,   2'd0, 16'h0000, 1'b1, 5'd8, 20'h00055, 1'b0},
        '{ROW_CMD, CMD_FLAG,   2'd0, 16'h0000, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h00A5, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_CRC,    2'd0, 16'h0000, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CFG, CMD_START,  REG_SCRAMBLE_START_BIT, 16'hFFFF, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CFG, CMD_START,  REG_NRZI_ENABLE, 16'd0, 1'b0, 5'd0, 20'h0, 1'b0},
        '{ROW_CMD, CMD_START,  2'd0, 16'h0000, 1'b1, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_DATA,   2'd0, 16'h003C, 1'b0, 5'd0, 20'h00000, 1'b0},
        '{ROW_CMD, CMD_CRC,    2'd0, 16'h0000, 1'b0, 5'd0, 20'h00000, 1'b0}
    };

    hdlc_tx_bit_framer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Puts one line bit through the scrambler and NRZI coder; false once the frame is full.
    function automatic logic emit_line_bit(input logic b);
        logic v;
        v = b;
        if (bit_idx >= cfg_now.frame_bit_limit) begin
            return 1'b0;
        end
        if (cfg_now.scramble_enable && bit_idx >= cfg_now.scramble_start_bit) begin
            v = v ^ scr_shift[SCR_TAP_HI] ^ scr_shift[SCR_TAP_LO];
            scr_shift = {scr_shift[15:0], v};
        end
        if (cfg_now.nrzi_enable) begin
            if (!v) begin
                tone = ~tone;
            end
            v = tone;
        end
        cmd_bits.push_back('{v, 1'b0, 1'b0});
        bit_idx++;
        return 1'b1;
    endfunction

    function automatic logic send_raw_byte(input logic [7:0] by);
        for (int i = 0; i < 8; i++) begin
            if (!emit_line_bit(by[i])) begin
                return 1'b0;
            end
            if (!by[i]) begin
                ones_cnt = '0;
            end
        end
        return 1'b1;
    endfunction

    // The CRC takes the data bit before the limit test, so a dropped bit still counts.
    function automatic logic send_stuffed_byte(input logic [7:0] by);
        logic [15:0] c;
        for (int i = 0; i < 8; i++) begin
            c = crc_acc ^ {15'd0, by[i]};
            crc_acc = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            if (by[i]) begin
                if (!emit_line_bit(1'b1)) begin
                    return 1'b0;
                end
                ones_cnt++;
                if (ones_cnt < STUFF_RUN) begin
                    continue;
                end
            end
            if (!emit_line_bit(1'b0)) begin
                return 1'b0;
            end
            ones_cnt = '0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_line_bits(input logic [2:0] cmd, input logic [7:0] by);
        logic        ok;
        logic [15:0] snap;
        line_res_t   tail;
        ok = 1'b1;
        cmd_bits.delete();
        case (cmd)
            CMD_START: begin
                bit_idx = '0;
                ones_cnt = '0;
                tone = 1'b0;
                scr_shift = '0;
                crc_acc = CRC_INIT;
            end
            CMD_SYNC: ok = send_raw_byte(SYNC_BYTE);
            CMD_FLAG: ok = send_raw_byte(FLAG_BYTE);
            CMD_DATA: ok = send_stuffed_byte(by);
            CMD_CRC: begin
                snap = crc_acc;
                ok = send_stuffed_byte(~snap[7:0]);
                if (ok) begin
                    ok = send_stuffed_byte(~snap[15:8]);
                end
            end
            default: ;
        endcase
        if (cmd_bits.size() > 0) begin
            tail = cmd_bits.pop_back();
            tail.last_bit = 1'b1;
            tail.frame_full = !ok;
            cmd_bits.push_back(tail);
        end
    endfunction

    // Requests are predicted and results checked at the same clock edge the DUT samples them.
    always @(posedge aclk) begin
        line_res_t want;
        line_res_t got;
        if (aresetn && s_tvalid && s_tready) begin
            predict_line_bits(s_tdata[2:0], s_tdata[10:3]);
            if (row_typed) begin
                for (int i = 0; i < row_n; i++) begin
                    line_bits_due.push_back('{row_bits[i], i == row_n - 1,
                                              (i == row_n - 1) && row_full});
                end
            end else begin
                foreach (cmd_bits[i]) line_bits_due.push_back(cmd_bits[i]);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tlast, m_tuser[0]};
            if (line_bits_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected line bit: expected none, got bit=%b last=%b full=%b",
                         $time, got.line_bit, got.last_bit, got.frame_full);
            end else begin
                want = line_bits_due.pop_front();
                if (got.line_bit !== want.line_bit || got.last_bit !== want.last_bit ||
                    got.frame_full !== want.frame_full) begin
                    err_cnt++;
                    $display("%0t: line bit mismatch (bit last full): expected %b%b%b, got %b%b%b",
                             $time, want.line_bit, want.last_bit, want.frame_full,
                             got.line_bit, got.last_bit, got.frame_full);
                end
            end
        end
    end

    // Receiver side: random stalls, or a long hold-off while one is pending.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic push_cmd(input logic [2:0] cmd, input logic [7:0] by, input logic typed,
                            input logic [4:0] n, input logic [19:0] bits, input logic full);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({by, cmd});
        row_typed <= typed;
        row_n <= n;
        row_bits <= bits;
        row_full <= full;
        do @(posedge aclk); while (!s_tready);
        if (cmd <= CMD_CRC) begin
            items_sent++;
        end
    endtask

    task automatic send_rand(input logic [2:0] cmd, input logic [7:0] by);
        push_cmd(cmd, by, 1'b0, '0, '0, 1'b0);
    endtask

    // Waits until every expected bit has come, then lets queued result-free requests retire.
    // The first edge lets the checker record the request accepted at the edge just passed.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (line_bits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_BIT_LIMIT:    cfg_now.frame_bit_limit = value[15:0];
            REG_SCRAMBLE_ENABLE:    cfg_now.scramble_enable = value[0];
            REG_SCRAMBLE_START_BIT: cfg_now.scramble_start_bit = value[15:0];
            REG_NRZI_ENABLE:        cfg_now.nrzi_enable = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_framing(input logic [15:0] limit, input logic scr,
                               input logic [15:0] start, input logic nrzi);
        settle();
        write_reg(REG_FRAME_BIT_LIMIT, 32'(limit));
        write_reg(REG_SCRAMBLE_ENABLE, 32'(scr));
        write_reg(REG_SCRAMBLE_START_BIT, 32'(start));
        write_reg(REG_NRZI_ENABLE, 32'(nrzi));
    endtask

    // Leans toward runs of ones so that stuffing happens often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(6))
            0: return 8'hFF;
            1: return FLAG_BYTE;
            2: return 8'h00;
            3: return 8'hF8 | 8'($urandom_range(7));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame(input int max_data);
        send_rand(CMD_START, pick_byte());
        repeat ($urandom_range(2)) send_rand(CMD_SYNC, pick_byte());
        repeat ($urandom_range(1, 2)) send_rand(CMD_FLAG, pick_byte());
        repeat ($urandom_range(1, max_data)) send_rand(CMD_DATA, pick_byte());
        send_rand(CMD_CRC, pick_byte());
        send_rand(CMD_FLAG, pick_byte());
    endtask

    task automatic send_noise();
        case ($urandom_range(3))
            0: repeat ($urandom_range(1, 4)) send_rand(3'($urandom_range(7)), pick_byte());
            1: begin
                repeat ($urandom_range(1, 5)) send_rand(CMD_DATA, pick_byte());
                send_rand(CMD_CRC, pick_byte());
            end
            2: begin
                send_rand(CMD_CRC, pick_byte());
                send_rand(CMD_CRC, pick_byte());
                send_rand(CMD_FLAG, pick_byte());
            end
            default: begin
                send_rand(CMD_START, pick_byte());
                send_rand(CMD_START, pick_byte());
                send_rand(CMD_CRC, pick_byte());
            end
        endcase
    endtask

    initial begin
        int          goal;
        logic        paused;
        logic [15:0] limit;
        logic [15:0] start;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].reg_idx, 32'(dir_rows[i].val));
            end else begin
                push_cmd(dir_rows[i].cmd, dir_rows[i].val[7:0], dir_rows[i].typed,
                         dir_rows[i].nbits, dir_rows[i].bits, dir_rows[i].full);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 73; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 73; end
                default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
            endcase
            if (ph == 0) begin
                set_framing(LIMIT_RESET, 1'b0, SCR_START_RESET, 1'b0);
            end else if (ph == 1) begin
                set_framing(16'hFFFF, 1'b1, 16'd0, 1'b1);
            end else begin
                case ($urandom_range(3))
                    0: limit = 16'($urandom_range(16, 300));
                    1: limit = LIMIT_RESET;
                    2: limit = 16'hFFFF;
                    default: limit = 16'($urandom_range(60, 160));
                endcase
                case ($urandom_range(2))
                    0: start = 16'd0;
                    1: start = 16'($urandom_range(80));
                    default: start = 16'hFFFF;
                endcase
                set_framing(limit, 1'($urandom_range(1)), start, 1'($urandom_range(1)));
            end
            // A long receiver hold-off lets the request queue fill and stall the input.
            if (ph % 4 == 2) begin
                hold_left = HOLD_CYCLES;
            end
            goal = items_sent + PHASE_ITEMS;
            paused = 1'b0;
            while (items_sent < goal) begin
                if (!paused && items_sent >= goal - PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (line_bits_due.size() != 0) @(posedge aclk);
                    @(posedge aclk);
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 80) begin
                    send_frame(($urandom_range(9) == 0) ? 30 : 8);
                end else begin
                    send_noise();
                end
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
